// File: design/edfss_pkg.sv
// Package for the EDF slice scheduler: shared constants, register codes and the
// structs passed between the top level and the scan cells.
// No dependencies.
`timescale 1ns / 1ps

package edfss_pkg;

    localparam int unsigned TASK_SLOTS_DEF = 16;
    localparam int unsigned IDX_W          = 6;
    localparam int unsigned SLOT_W         = 4;
    localparam int unsigned TIME_W         = 32;
    localparam int unsigned ID_W           = 8;
    localparam int unsigned COUNT_W        = 5;
    localparam int unsigned SLICE_W        = 16;

    localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd1000;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic REG_TASK_COUNT   = 1'b0;
    localparam logic REG_SLICE_LENGTH = 1'b1;

    typedef struct packed {
        logic              valid;
        logic              found;
        logic [TIME_W-1:0] deadline;
        logic [IDX_W-1:0]  idx;
        logic [ID_W-1:0]   id;
    } token_t;

    typedef struct packed {
        logic               load_en;
        logic [SLOT_W-1:0]  load_slot;
        logic [TIME_W-1:0]  arrival;
        logic [TIME_W-1:0]  run;
        logic [TIME_W-1:0]  deadline;
        logic [ID_W-1:0]    id;
        logic               dec_en;
        logic [IDX_W-1:0]   dec_idx;
        logic [SLICE_W-1:0] slice;
        logic [TIME_W-1:0]  time_now;
        logic [COUNT_W-1:0] task_count;
    } cell_cmd_t;

endpackage

// File: design/edfss_cell.sv
// One task slot of the scan chain: holds the slot's task and compares it
// against the best candidate handed in by the previous cell.
// Depends on edfss_pkg.
`timescale 1ns / 1ps

module edfss_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  edfss_pkg::cell_cmd_t cmd,
    input  edfss_pkg::token_t  tok_in,
    output edfss_pkg::token_t  tok_out
);
    import edfss_pkg::*;

    logic [TIME_W-1:0] arrival_reg;
    logic [TIME_W-1:0] remaining_reg;
    logic [TIME_W-1:0] deadline_reg;
    logic [ID_W-1:0]   id_reg;
    token_t            tok_reg;
    token_t            tok_next;
    logic              in_range;
    logic              eligible;
    logic              load_hit;
    logic              dec_hit;
    logic [TIME_W-1:0] slice_ext;
    logic [TIME_W-1:0] remaining_next;

    assign in_range  = IDX_W'(IDX) < {1'b0, cmd.task_count};
    assign eligible  = in_range && (arrival_reg <= cmd.time_now) && (remaining_reg != '0)
                       && (deadline_reg < tok_in.deadline);
    assign load_hit  = cmd.load_en && ({{(IDX_W-SLOT_W){1'b0}}, cmd.load_slot} == IDX_W'(IDX));
    assign dec_hit   = cmd.dec_en && (cmd.dec_idx == IDX_W'(IDX));
    assign slice_ext = {{(TIME_W-SLICE_W){1'b0}}, cmd.slice};

    always_comb begin
        remaining_next = (remaining_reg > slice_ext) ? (remaining_reg - slice_ext) : '0;
        tok_next       = tok_in;
        if (eligible) begin
            tok_next.found    = 1'b1;
            tok_next.deadline = deadline_reg;
            tok_next.idx      = IDX_W'(IDX);
            tok_next.id       = id_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_hit) begin
            arrival_reg   <= cmd.arrival;
            remaining_reg <= cmd.run;
            deadline_reg  <= cmd.deadline;
            id_reg        <= cmd.id;
        end else if (dec_hit) begin
            remaining_reg <= remaining_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// File: design/edf_slice_scheduler_unit.sv
// Top level of the EDF slice scheduler: stream ports, APB registers, tick
// sequencing and the chain of edfss_cell task slots.
// Depends on edfss_pkg and edfss_cell.
//
//  channel   | ports            | carries
//  ----------+------------------+------------------------------------------
//  s_axis    | tvalid/tready    | load (tuser 0) or tick (tuser 1) request
//  m_axis    | tvalid/tready    | one result per tick, none per load
//  apb       | psel/penable/... | task_count (0x0), slice_length (0x4)
//
// During a tick the candidate moves one cell per cycle down the slot chain;
// a tick while halted skips the chain and goes straight to ST_DONE.
// Reset is synchronous, active low; slot contents are not cleared.
// A result waits in the output register; a tick stalls in ST_DONE only
// while that register is still full and m_axis_tready is low.
`timescale 1ns / 1ps

module edf_slice_scheduler_unit #(
    parameter int unsigned TASK_SLOTS = edfss_pkg::TASK_SLOTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // slot[3:0], arrival_ms[35:4], run_ms[67:36], deadline_ms[99:68],
    // task_id[107:100], zero[111:108]
    input  logic [111:0] s_axis_tdata,
    // kind[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // chosen_slot[3:0], chosen_id[11:4], slice_time[43:12], zero[47:44]
    output logic [47:0]  m_axis_tdata,
    // task_valid[0]
    output logic         m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import edfss_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic                halted_reg, halted_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [COUNT_W-1:0]  task_count_reg;
    logic [SLICE_W-1:0]  slice_reg;
    token_t              pick_reg, pick_next;
    logic                m_valid_reg, m_valid_next;
    logic                res_valid_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic [ID_W-1:0]     res_id_reg;
    logic [TIME_W-1:0]   res_time_reg;

    logic                accept;
    logic                load;
    logic                tick;
    logic                commit;
    logic                cfg_wr;
    cell_cmd_t           cmd;
    token_t              tok [0:TASK_SLOTS];
    logic [TASK_SLOTS-1:0] tok_valid_vec;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign load          = accept && (s_axis_tuser == KIND_LOAD);
    assign tick          = accept && (s_axis_tuser == KIND_TICK);
    assign commit        = (state_reg == ST_DONE) && (!m_valid_reg || m_axis_tready);

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            task_count_reg <= '0;
            slice_reg      <= SLICE_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_TASK_COUNT:   task_count_reg <= pwdata[COUNT_W-1:0];
                REG_SLICE_LENGTH: slice_reg      <= pwdata[SLICE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TASK_COUNT:   prdata = {{(32-COUNT_W){1'b0}}, task_count_reg};
            REG_SLICE_LENGTH: prdata = {{(32-SLICE_W){1'b0}}, slice_reg};
            default:          prdata = '0;
        endcase
    end

    // broadcast to the cells
    always_comb begin
        cmd.load_en    = load;
        cmd.load_slot  = s_axis_tdata[3:0];
        cmd.arrival    = s_axis_tdata[35:4];
        cmd.run        = s_axis_tdata[67:36];
        cmd.deadline   = s_axis_tdata[99:68];
        cmd.id         = s_axis_tdata[107:100];
        cmd.dec_en     = commit && pick_reg.found;
        cmd.dec_idx    = pick_reg.idx;
        cmd.slice      = slice_reg;
        cmd.time_now   = time_reg;
        cmd.task_count = task_count_reg;
    end

    assign tok[0] = '{valid: tick && !halted_reg, found: 1'b0, deadline: '1,
                      idx: '0, id: '0};

    for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
        edfss_cell #(
            .IDX (g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cmd     (cmd),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1])
        );
        assign tok_valid_vec[g] = tok[g+1].valid;
    end

    // tick sequencing
    always_comb begin
        state_next   = state_reg;
        halted_next  = halted_reg;
        time_next    = time_reg;
        pick_next    = pick_reg;
        m_valid_next = m_valid_reg;
        if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (load) begin
                    halted_next = 1'b0;
                end
                if (tick) begin
                    if (halted_reg) begin
                        pick_next.found = 1'b0;
                        state_next      = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (tok[TASK_SLOTS].valid) begin
                    pick_next  = tok[TASK_SLOTS];
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (commit) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (pick_reg.found) begin
                        time_next = time_reg + {{(TIME_W-SLICE_W){1'b0}}, slice_reg};
                    end else begin
                        halted_next = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            halted_reg  <= 1'b0;
            time_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            halted_reg  <= halted_next;
            time_reg    <= time_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pick_reg <= pick_next;
        if (commit) begin
            res_valid_reg <= pick_reg.found;
            res_slot_reg  <= pick_reg.found ? pick_reg.idx[SLOT_W-1:0] : '0;
            res_id_reg    <= pick_reg.found ? pick_reg.id : '0;
            res_time_reg  <= time_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = res_valid_reg;
    assign m_axis_tdata  = {4'b0000, res_time_reg, res_id_reg, res_slot_reg};

`ifndef ASSERT_OFF
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(tok_valid_vec) <= 1)
        else $error("more than one candidate in the slot chain");

    a_tail_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        tok[TASK_SLOTS].valid |-> (state_reg == ST_SCAN))
        else $error("candidate left the chain outside a scan");

    a_idle_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && !pick_reg.found) |=> (halted_reg && !m_axis_tuser))
        else $error("idle result did not halt the scheduler");

    a_idle_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && !pick_reg.found) |=> $stable(time_reg))
        else $error("time advanced on an idle result");

    a_commit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwrote an untaken result");
`endif

endmodule
